// ----- rtl/tcq_pkg.sv -----
// Shared types and constants for the triangle centroid Q12 transform.
// No dependencies; every other file of the block imports this package.
package tcq_pkg;

   localparam int COORD_W = 16;
   localparam int COEF_W  = 17;
   localparam int ROW_W   = 3 * COEF_W;
   localparam int QUOT_W  = COORD_W + COEF_W - 12;   // one product after /4096
   localparam int CEN_W   = 22;

   // 1/3 as ceil(2^17/3); exact floor for magnitudes below 2^17
   localparam logic [16:0] DIV3_MULT  = 17'd43691;
   localparam int          DIV3_SHIFT = 17;

   // Q12 one and the reset matrix rows (identity)
   localparam logic [ROW_W-1:0] Q12_ONE     = ROW_W'(4096);
   localparam logic [ROW_W-1:0] RESET_ROW_X = Q12_ONE;
   localparam logic [ROW_W-1:0] RESET_ROW_Y = Q12_ONE << COEF_W;
   localparam logic [ROW_W-1:0] RESET_ROW_Z = Q12_ONE << (2 * COEF_W);

   // Register index codes (byte address bits [4:3])
   localparam logic [1:0] CSR_COEF_X = 2'd0;
   localparam logic [1:0] CSR_COEF_Y = 2'd1;
   localparam logic [1:0] CSR_COEF_Z = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [QUOT_W-1:0]  quot_type;

   // index 0 = x, 1 = y, 2 = z
   typedef logic [2:0][COORD_W-1:0] vec_type;
   // vertices a, b, c
   typedef vec_type [2:0] tri_type;
   // offsets of a, b, c at 0..2, centroid at 3
   typedef vec_type [3:0] center_type;
   // matrix rows for output x, y, z
   typedef logic [2:0][ROW_W-1:0] coef_mat_type;

   typedef struct packed {
      logic [2:0][2:0][COORD_W-1:0] rel;   // [vertex][axis]
      logic [2:0][CEN_W-1:0]        cen;   // [axis]
   } result_type;

endpackage

// ----- rtl/tcq_csr.sv -----
// Configuration registers of the centroid transform: three 51-bit matrix rows.
// Depends on tcq_pkg.
module tcq_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [63:0]          csr_pwdata,
   output logic [63:0]          csr_prdata,
   output logic                 csr_pready,
   output tcq_pkg::coef_mat_type coef
);
   import tcq_pkg::*;

   logic [ROW_W-1:0] row_x_ff, row_x_in;
   logic [ROW_W-1:0] row_y_ff, row_y_in;
   logic [ROW_W-1:0] row_z_ff, row_z_in;
   logic             wr_en;
   logic [ROW_W-1:0] rd_row;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      row_x_in = row_x_ff;
      row_y_in = row_y_ff;
      row_z_in = row_z_ff;
      if (wr_en) begin
         case (csr_paddr[4:3])
            CSR_COEF_X: row_x_in = csr_pwdata[ROW_W-1:0];
            CSR_COEF_Y: row_y_in = csr_pwdata[ROW_W-1:0];
            CSR_COEF_Z: row_z_in = csr_pwdata[ROW_W-1:0];
            default:    ;   // no register there
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff <= RESET_ROW_X;
         row_y_ff <= RESET_ROW_Y;
         row_z_ff <= RESET_ROW_Z;
      end else begin
         row_x_ff <= row_x_in;
         row_y_ff <= row_y_in;
         row_z_ff <= row_z_in;
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         CSR_COEF_X: rd_row = row_x_ff;
         CSR_COEF_Y: rd_row = row_y_ff;
         CSR_COEF_Z: rd_row = row_z_ff;
         default:    rd_row = '0;
      endcase
   end

   assign csr_prdata = {{(64 - ROW_W){1'b0}}, rd_row};
   assign coef       = {row_z_ff, row_y_ff, row_x_ff};

endmodule

// ----- rtl/tcq_center.sv -----
// Centroid stage: per-axis sum / 3 (toward zero) and wrapped vertex offsets.
// Depends on tcq_pkg. One register stage.
module tcq_center (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tcq_pkg::tri_type    in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output tcq_pkg::center_type out_data
);
   import tcq_pkg::*;

   logic       valid_ff, valid_in;
   center_type data_ff, data_in;

   // (a + b + c) / 3 truncated toward zero; result always fits 16 bits
   function automatic coord_type centroid3(input coord_type a, input coord_type b,
                                           input coord_type c);
      logic signed [17:0] sum;
      logic [16:0]        mag;
      logic [32:0]        prod;
      logic [16:0]        quo;
      logic [16:0]        sgn;
      sum  = 18'(a) + 18'(b) + 18'(c);
      mag  = sum[17] ? 17'(-sum) : sum[16:0];
      prod = 33'(mag) * 33'(DIV3_MULT);
      quo  = {1'b0, prod[32:DIV3_SHIFT]};
      sgn  = sum[17] ? (~quo + 17'd1) : quo;
      return sgn[15:0];
   endfunction

   always_comb begin
      coord_type cen;
      data_in = data_ff;
      for (int k = 0; k < 3; k++) begin
         cen = centroid3(in_data[0][k], in_data[1][k], in_data[2][k]);
         data_in[3][k] = cen;
         for (int i = 0; i < 3; i++) begin
            data_in[i][k] = in_data[i][k] - cen;   // wraps to 16 bits
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/tcq_xform.sv -----
// Matrix stage: 36 Q12 products (each truncated toward zero), then row sums.
// Depends on tcq_pkg. Two register stages: quotients, then results.
module tcq_xform (
   input  logic                 clock,
   input  logic                 reset,
   input  tcq_pkg::coef_mat_type coef,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tcq_pkg::center_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tcq_pkg::result_type  out_data
);
   import tcq_pkg::*;

   // [vector][out row][in axis]
   quot_type   quot_ff [4][3][3];
   quot_type   quot_in [4][3][3];
   logic       prod_valid_ff, prod_valid_in;
   logic       prod_load;
   result_type res_ff, res_in;
   logic       res_valid_ff, res_valid_in;
   logic       res_load;

   // v * c / 4096 truncated toward zero
   function automatic quot_type q12_mul(input coord_type v, input coef_type c);
      logic signed [32:0] prod;
      logic signed [32:0] adj;
      prod = 33'(v) * 33'(c);
      adj  = prod + (prod[32] ? 33'sd4095 : 33'sd0);
      return adj[32:12];
   endfunction

   always_comb begin
      for (int v = 0; v < 4; v++) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               quot_in[v][r][k] = q12_mul(in_data[v][k], coef[r][k*COEF_W +: COEF_W]);
            end
         end
      end
   end

   always_comb begin
      logic signed [CEN_W:0] sum;
      res_in = res_ff;
      for (int v = 0; v < 4; v++) begin
         for (int r = 0; r < 3; r++) begin
            sum = (CEN_W + 1)'(quot_ff[v][r][0]) + (CEN_W + 1)'(quot_ff[v][r][1])
                + (CEN_W + 1)'(quot_ff[v][r][2]);
            if (v == 3) begin
               res_in.cen[r] = sum[CEN_W-1:0];
            end else begin
               res_in.rel[v][r] = sum[COORD_W-1:0];
            end
         end
      end
   end

   assign res_load      = !res_valid_ff || out_ready;
   assign prod_load     = !prod_valid_ff || res_load;
   assign in_ready      = prod_load;
   assign prod_valid_in = prod_load ? in_valid : prod_valid_ff;
   assign res_valid_in  = res_load ? prod_valid_ff : res_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load && in_valid) begin
         quot_ff <= quot_in;
      end
      if (res_load && prod_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_data  = res_ff;

endmodule

// ----- rtl/triangle_centroid_q12_transform_unit.sv -----
// Top level of the triangle centroid Q12 transform.
// Depends on tcq_pkg, tcq_csr, tcq_center and tcq_xform.
//
// Usage:
//  - req_* : one triangle per item, three vertices (signed 16-bit x, y, z) in tdata,
//    batch marker in tlast (carried for the sender only, it does not
//    change any result).
//  - rsp_* : one result item per triangle: nine wrapped 16-bit transformed
//    offsets and the 22-bit transformed centroid.
//  - csr_* : three 51-bit matrix rows at byte addresses 0, 8, 16; write only
//    while the block is idle. Reset loads the identity matrix.
// Pipeline: input register, centroid/offset stage, product stage, sum stage.
// Each stage register holds one item; a new triangle can be taken every
// cycle while rsp_tready is high. An accepted triangle loads the input
// register, then the centroid, product and sum registers in turn, and the
// sum register drives rsp_tvalid. Throughput is one item per clock while
// rsp_tready is high; each stage hands on in the same cycle it takes a new one.
// Reset empties every stage. When rsp_tready is low the pipeline still
// accepts items until every stage holds one; then req_tready drops.
module triangle_centroid_q12_transform_unit (
   input  logic          clock,
   input  logic          reset,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each, from bit 0)
   input  logic [143:0]  req_tdata,
   input  logic          req_tlast,   // last_triangle
   input  logic          req_tvalid,
   output logic          req_tready,
   // rel_a_x, rel_a_y, rel_a_z, rel_b_x .. rel_c_z (16 bits each),
   // centroid_x, centroid_y, centroid_z (22 bits each), zero fill [215:210]
   output logic [215:0]  rsp_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);
   import tcq_pkg::*;

   // input register
   logic         in_valid_ff, in_valid_in;
   tri_type      in_data_ff;
   logic         in_last_ff;    // batch marker is held but has no effect on results
   logic         accept;

   coef_mat_type coef;
   logic         center_ready;
   logic         center_valid;
   center_type   center_data;
   logic         xform_ready;
   result_type   result;

   tcq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // Stage 0: capture the triangle
   assign req_tready  = !in_valid_ff || center_ready;
   assign accept      = req_tvalid && req_tready;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Stage 1: centroid and offsets
   tcq_center u_center (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (center_ready),
      .in_data   (in_data_ff),
      .out_valid (center_valid),
      .out_ready (xform_ready),
      .out_data  (center_data)
   );

   // Stages 2 and 3: products, then sums into the result register
   tcq_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_valid  (center_valid),
      .in_ready  (xform_ready),
      .in_data   (center_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   // pack: vertex offsets low, centroid above, zero fill on top
   assign rsp_tdata = {6'd0, result.cen, result.rel};

endmodule
